>>> hdl/mqph_pkg.sv
// package: shared types and constants for the message queue hand-off unit
package mqph_pkg;
	localparam int QueueSlotsDef  = 8;
	localparam int RingDepthDef   = 16;
	localparam int ThreadCountDef = 16;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_SEND    = 2'd1,
		OP_RECEIVE = 2'd2,
		OP_CANCEL  = 2'd3
	} op_t;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FAILED = 2'd1;
	localparam logic [1:0] ST_PARKED = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_QSCAN,
		S_QDONE,
		S_WSCAN,
		S_DECIDE,
		S_POP_RD,
		S_POP_WAIT,
		S_ADMIT,
		S_WRAP,
		S_RESULT
	} state_t;
endpackage

>>> hdl/mqph_ram.sv
// generic single-port ram with registered read
module mqph_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> hdl/message_queue_priority_handoff_unit.sv
// top level: message queue unit with priority hand-off between parked threads
//
// channel  direction  handshake          fields
// in       to block   in_valid/in_ready  op, object_key, message, requested_capacity,
//                                        dest_address, may_wait, caller_thread,
//                                        caller_priority
// out      from block out_valid/out_ready status, write_valid, write_address,
//                                        write_word, wake_valid, wake_thread, preempt
//
// one transaction at a time: no accept until the result of the last one is taken;
// the queue table is scanned one entry per cycle, stopping at a key match, and the
// thread table one entry per cycle, followed by pop, admit, wrap check and result
// states as the operation needs
// a ring position left beyond a reduced capacity takes extra steps in the wrap state
// reset clears queue in-use and parked marks only; no clearing pass
// a stalled result holds in the output register; no new transaction until taken
module message_queue_priority_handoff_unit
	import mqph_pkg::*;
#(
	parameter int QUEUE_SLOTS  = QueueSlotsDef,
	parameter int RING_DEPTH   = RingDepthDef,
	parameter int THREAD_COUNT = ThreadCountDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [31:0]        object_key,
	input  logic [31:0]        message,
	input  logic signed [31:0] requested_capacity,
	input  logic [31:0]        dest_address,
	input  logic               may_wait,
	input  logic [3:0]         caller_thread,
	input  logic [7:0]         caller_priority,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic               write_valid,
	output logic [31:0]        write_address,
	output logic [31:0]        write_word,
	output logic               wake_valid,
	output logic [3:0]         wake_thread,
	output logic               preempt
);
	localparam int QW  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int TW  = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
	localparam int RW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW  = $clog2(RING_DEPTH + 1);
	localparam int MD  = QUEUE_SLOTS * RING_DEPTH;
	localparam int MW  = (MD > 1) ? $clog2(MD) : 1;
	localparam int QCW = $clog2(QUEUE_SLOTS + 1);
	localparam int TCW = $clog2(THREAD_COUNT + 1);
	localparam logic [CW-1:0] DepthC = CW'(RING_DEPTH);

	state_t state_q, state_d;

	// captured transaction
	op_t         op_q;
	logic [31:0] key_q, msg_q, cap_q, dest_q;
	logic        wait_q;
	logic [3:0]  me_q;
	logic [7:0]  prio_q;

	// queue table
	logic [QUEUE_SLOTS-1:0] q_use_q;
	logic [31:0]   q_key_q  [QUEUE_SLOTS];
	logic [CW-1:0] q_cap_q  [QUEUE_SLOTS];
	logic [RW-1:0] q_head_q [QUEUE_SLOTS];
	logic [RW-1:0] q_tail_q [QUEUE_SLOTS];
	logic [CW-1:0] q_fill_q [QUEUE_SLOTS];

	// thread table
	logic [THREAD_COUNT-1:0] w_park_q;
	logic [QW-1:0] w_queue_q [THREAD_COUNT];
	logic          w_snd_q   [THREAD_COUNT];
	logic [7:0]    w_prio_q  [THREAD_COUNT];
	logic [31:0]   w_word_q  [THREAD_COUNT];
	logic [31:0]   w_dest_q  [THREAD_COUNT];

	// scan state
	logic [QCW-1:0] qi_q;
	logic [TCW-1:0] ti_q;
	logic           found_q, free_found_q;
	logic [QW-1:0]  slot_q, free_q;
	logic           best_v_q;
	logic [TW-1:0]  best_q;
	logic [7:0]     best_prio_q;

	// result register
	logic [1:0]  st_q;
	logic        wv_q, kv_q, pre_q;
	logic [31:0] wa_q, ww_q;
	logic [3:0]  kt_q;

	// message store
	logic          ram_we;
	logic [MW-1:0] ram_addr;
	logic [31:0]   ram_wdata, ram_rdata;

	mqph_ram #(.Width(32), .Depth(MD)) u_store (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// compare logic: key match during queue scan, waiter rank during thread scan
	logic [QW-1:0] qi_idx;
	logic [TW-1:0] ti_idx;
	logic          key_hit, cand, better;
	assign qi_idx  = qi_q[QW-1:0];
	assign ti_idx  = ti_q[TW-1:0];
	assign key_hit = q_use_q[qi_idx] && (q_key_q[qi_idx] == key_q);
	assign cand    = w_park_q[ti_idx] && (w_queue_q[ti_idx] == slot_q) &&
		(w_snd_q[ti_idx] == (op_q == OP_RECEIVE));
	assign better  = cand && (!best_v_q || (w_prio_q[ti_idx] > best_prio_q));

	// derived per-slot values
	logic [CW-1:0] cap_s, rcap_s, fill_s;
	logic [RW-1:0] head_s, tail_s;
	assign cap_s  = q_cap_q[slot_q];
	assign rcap_s = (cap_s == '0) ? CW'(1) : cap_s;
	assign fill_s = q_fill_q[slot_q];
	assign head_s = q_head_q[slot_q];
	assign tail_s = q_tail_q[slot_q];

	// wrap unit: steps an advanced ring position left beyond a cut capacity into range
	logic          hwrap_q, twrap_q, head_ge, tail_ge;
	logic [CW-1:0] wrap_dif;
	assign head_ge  = hwrap_q && (CW'(head_s) >= rcap_s);
	assign tail_ge  = twrap_q && (CW'(tail_s) >= rcap_s);
	assign wrap_dif = (head_ge ? CW'(head_s) : CW'(tail_s)) - rcap_s;

	// one wrap step here; the wrap state finishes it after a capacity cut
	function automatic logic [RW-1:0] ring_next(input logic [RW-1:0] p,
		input logic [CW-1:0] c);
		logic [CW:0] n;
		n = {{(CW+1-RW){1'b0}}, p} + (CW+1)'(1);
		if (n >= {1'b0, c}) n = n - {1'b0, c};
		return n[RW-1:0];
	endfunction

	logic [MW-1:0] head_addr, tail_addr;
	assign head_addr = MW'(slot_q) * MW'(RING_DEPTH) + MW'(head_s);
	assign tail_addr = MW'(slot_q) * MW'(RING_DEPTH) + MW'(tail_s);

	// capacity normalization
	logic [CW-1:0] cap_norm;
	assign cap_norm = (!cap_q[31] && cap_q != 32'd0 && cap_q <= 32'(RING_DEPTH)) ?
		CW'(cap_q) : DepthC;

	logic me_ok;
	assign me_ok = 32'(me_q) < 32'(THREAD_COUNT);
	logic [TW-1:0] me_idx;
	assign me_idx = TW'(me_q);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESULT);
	assign status        = st_q;
	assign write_valid   = wv_q;
	assign write_address = wa_q;
	assign write_word    = ww_q;
	assign wake_valid    = kv_q;
	assign wake_thread   = kt_q;
	assign preempt       = pre_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_QSCAN;
			S_QSCAN:  if (qi_q == QCW'(QUEUE_SLOTS - 1) || key_hit) state_d = S_QDONE;
			S_QDONE: begin
				if (op_q == OP_CREATE || op_q == OP_CANCEL || !found_q) state_d = S_RESULT;
				else state_d = S_WSCAN;
			end
			S_WSCAN:  if (ti_q == TCW'(THREAD_COUNT - 1)) state_d = S_DECIDE;
			S_DECIDE: begin
				if (op_q == OP_RECEIVE && fill_s != '0) state_d = S_POP_RD;
				else if (op_q == OP_SEND && !best_v_q && fill_s < cap_s) state_d = S_WRAP;
				else state_d = S_RESULT;
			end
			S_POP_RD:   state_d = S_POP_WAIT;
			S_POP_WAIT: state_d = best_v_q ? S_ADMIT : S_WRAP;
			S_ADMIT:    state_d = S_WRAP;
			S_WRAP:     if (!head_ge && !tail_ge) state_d = S_RESULT;
			S_RESULT:   if (out_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// store port control
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = head_addr;
		ram_wdata = msg_q;
		case (state_q)
			S_DECIDE: begin
				if (op_q == OP_SEND && !best_v_q && fill_s < cap_s) begin
					ram_we   = 1'b1;
					ram_addr = tail_addr;
				end
			end
			S_ADMIT: begin
				ram_we    = 1'b1;
				ram_addr  = tail_addr;
				ram_wdata = w_word_q[best_q];
			end
			default: ram_addr = head_addr;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			q_use_q  <= '0;
			w_park_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_QDONE: begin
					if (op_q == OP_CREATE) begin
						if (!found_q && free_found_q) q_use_q[free_q] <= 1'b1;
					end else if (op_q == OP_CANCEL) begin
						if (me_ok) w_park_q[me_idx] <= 1'b0;
					end
				end
				S_DECIDE: begin
					if (best_v_q && (op_q == OP_SEND ||
						(op_q == OP_RECEIVE && fill_s == '0))) begin
						w_park_q[best_q] <= 1'b0;
					end else if (!best_v_q && me_ok &&
						((op_q == OP_SEND && fill_s >= cap_s && wait_q) ||
						 (op_q == OP_RECEIVE && fill_s == '0))) begin
						w_park_q[me_idx] <= 1'b1;
					end
				end
				S_ADMIT: w_park_q[best_q] <= 1'b0;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= op_t'(op);
				key_q  <= object_key;
				msg_q  <= message;
				cap_q  <= requested_capacity;
				dest_q <= dest_address;
				wait_q <= may_wait;
				me_q   <= caller_thread;
				prio_q <= caller_priority;
				qi_q   <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				free_q       <= '0;
				slot_q       <= '0;
				hwrap_q      <= 1'b0;
				twrap_q      <= 1'b0;
				st_q  <= ST_DONE;
				wv_q  <= 1'b0;
				wa_q  <= '0;
				ww_q  <= '0;
				kv_q  <= 1'b0;
				kt_q  <= '0;
				pre_q <= 1'b0;
			end
			S_QSCAN: begin
				if (key_hit) begin
					found_q <= 1'b1;
					slot_q  <= qi_idx;
				end
				if (!q_use_q[qi_idx] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q       <= qi_idx;
				end
				qi_q <= qi_q + QCW'(1);
			end
			S_QDONE: begin
				ti_q        <= '0;
				best_v_q    <= 1'b0;
				best_q      <= '0;
				best_prio_q <= '0;
				if (op_q == OP_CREATE) begin
					if (found_q) begin
						q_cap_q[slot_q] <= cap_norm;
					end else if (free_found_q) begin
						q_key_q[free_q]  <= key_q;
						q_head_q[free_q] <= '0;
						q_tail_q[free_q] <= '0;
						q_fill_q[free_q] <= '0;
						q_cap_q[free_q]  <= cap_norm;
					end
				end else if (op_q != OP_CANCEL && !found_q) begin
					st_q <= ST_FAILED;
				end
			end
			S_WSCAN: begin
				if (better) begin
					best_v_q    <= 1'b1;
					best_q      <= ti_idx;
					best_prio_q <= w_prio_q[ti_idx];
				end
				ti_q <= ti_q + TCW'(1);
			end
			S_DECIDE: begin
				if (op_q == OP_SEND) begin
					if (best_v_q) begin
						wv_q  <= 1'b1;
						wa_q  <= w_dest_q[best_q];
						ww_q  <= msg_q;
						kv_q  <= 1'b1;
						kt_q  <= 4'(best_q);
						pre_q <= best_prio_q > prio_q;
					end else if (fill_s < cap_s) begin
						q_tail_q[slot_q] <= ring_next(tail_s, rcap_s);
						q_fill_q[slot_q] <= fill_s + CW'(1);
						twrap_q          <= 1'b1;
					end else if (!wait_q) begin
						st_q <= ST_FAILED;
					end else begin
						st_q <= ST_PARKED;
						if (me_ok) begin
							w_queue_q[me_idx] <= slot_q;
							w_snd_q[me_idx]   <= 1'b1;
							w_prio_q[me_idx]  <= prio_q;
							w_word_q[me_idx]  <= msg_q;
							w_dest_q[me_idx]  <= '0;
						end
					end
				end else if (fill_s == '0) begin
					if (best_v_q) begin
						wv_q  <= 1'b1;
						wa_q  <= dest_q;
						ww_q  <= w_word_q[best_q];
						kv_q  <= 1'b1;
						kt_q  <= 4'(best_q);
						pre_q <= best_prio_q > prio_q;
					end else begin
						st_q <= ST_PARKED;
						if (me_ok) begin
							w_queue_q[me_idx] <= slot_q;
							w_snd_q[me_idx]   <= 1'b0;
							w_prio_q[me_idx]  <= prio_q;
							w_word_q[me_idx]  <= '0;
							w_dest_q[me_idx]  <= dest_q;
						end
					end
				end else begin
					// pop: read issued this cycle, head moves on
					q_head_q[slot_q] <= ring_next(head_s, rcap_s);
					q_fill_q[slot_q] <= fill_s - CW'(1);
					hwrap_q          <= 1'b1;
				end
			end
			S_POP_RD: begin
				// read data of the old head is on the port this cycle
				wv_q <= 1'b1;
				wa_q <= dest_q;
				ww_q <= ram_rdata;
			end
			S_ADMIT: begin
				q_tail_q[slot_q] <= ring_next(tail_s, rcap_s);
				q_fill_q[slot_q] <= fill_s + CW'(1);
				twrap_q          <= 1'b1;
				kv_q <= 1'b1;
				kt_q <= 4'(best_q);
			end
			S_WRAP: begin
				if (head_ge) q_head_q[slot_q] <= RW'(wrap_dif);
				else if (tail_ge) q_tail_q[slot_q] <= RW'(wrap_dif);
			end
			default: ;
		endcase
	end
endmodule

>>> bench/message_queue_priority_handoff_unit_tb.sv
// testbench: message queue hand-off unit checked against a scoreboard predictor
module message_queue_priority_handoff_unit_tb;
	import mqph_pkg::*;

	localparam int NQ = QueueSlotsDef;
	localparam int ND = RingDepthDef;
	localparam int NT = ThreadCountDef;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 800;

	typedef struct {
		op_t              op;
		logic [31:0]      key;
		logic [31:0]      msg;
		logic signed [31:0] cap;
		logic [31:0]      dest;
		logic             mw;
		logic [3:0]       thr;
		logic [7:0]       prio;
	} call_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        wv;
		logic [31:0] wa;
		logic [31:0] ww;
		logic        kv;
		logic [3:0]  kt;
		logic        pre;
	} outcome_t;

	class mq_scoreboard;
		bit              in_use[NQ];
		bit [31:0]       qkey[NQ];
		int unsigned     qcap[NQ], qhead[NQ], qtail[NQ], qfill[NQ];
		bit [31:0]       ring[NQ*ND];
		bit              parked[NT];
		int unsigned     wq[NT];
		bit              wsend[NT];
		bit [7:0]        wprio[NT];
		bit [31:0]       wword[NT], wdest[NT];
		outcome_t        pending[$];
		int              errors = 0;
		int              checked = 0;
		int              wakes = 0;
		int              parks = 0;

		function int find(bit [31:0] k);
			for (int i = 0; i < NQ; i++)
				if (in_use[i] && qkey[i] == k) return i;
			return -1;
		endfunction

		function int fill_of(bit [31:0] k);
			int s;
			s = find(k);
			return (s < 0) ? -1 : int'(qfill[s]);
		endfunction

		function void push(int s, bit [31:0] w);
			int unsigned t;
			t = qtail[s] % ND;
			ring[s*ND + t] = w;
			qtail[s] = (t + 1) % ((qcap[s] == 0) ? 1 : qcap[s]);
			qfill[s]++;
		endfunction

		function bit [31:0] pop(int s);
			int unsigned h;
			h = qhead[s] % ND;
			qhead[s] = (h + 1) % ((qcap[s] == 0) ? 1 : qcap[s]);
			qfill[s]--;
			return ring[s*ND + h];
		endfunction

		function int best(int s, bit snd);
			int b;
			b = -1;
			for (int i = 0; i < NT; i++)
				if (parked[i] && wq[i] == s && wsend[i] == snd)
					if (b < 0 || wprio[i] > wprio[b]) b = i;
			return b;
		endfunction

		function void park(int t, int s, bit snd, bit [7:0] p, bit [31:0] w, bit [31:0] d);
			parked[t] = 1; wq[t] = s; wsend[t] = snd; wprio[t] = p; wword[t] = w; wdest[t] = d;
			parks++;
		endfunction

		// predict the outcome of one accepted call
		function void note_call(call_t c);
			outcome_t o;
			int s, w;
			o = '0;
			s = find(c.key);
			case (c.op)
				OP_CREATE: begin
					if (s < 0) begin
						for (int i = 0; i < NQ; i++)
							if (!in_use[i]) begin s = i; break; end
						if (s >= 0) begin
							in_use[s] = 1; qkey[s] = c.key;
							qhead[s] = 0; qtail[s] = 0; qfill[s] = 0;
						end
					end
					if (s >= 0)
						qcap[s] = (c.cap >= 1 && c.cap <= ND) ? c.cap : ND;
				end
				OP_SEND: begin
					w = (s < 0) ? -1 : best(s, 0);
					if (s < 0) o.status = ST_FAILED;
					else if (w >= 0) begin
						o.wv = 1; o.wa = wdest[w]; o.ww = c.msg;
						parked[w] = 0; o.kv = 1; o.kt = 4'(w);
						o.pre = wprio[w] > c.prio;
					end else if (qfill[s] < qcap[s]) push(s, c.msg);
					else if (!c.mw) o.status = ST_FAILED;
					else begin
						o.status = ST_PARKED;
						park(c.thr, s, 1, c.prio, c.msg, 0);
					end
				end
				OP_RECEIVE: begin
					w = (s < 0) ? -1 : best(s, 1);
					if (s < 0) o.status = ST_FAILED;
					else if (qfill[s] > 0) begin
						o.wv = 1; o.wa = c.dest; o.ww = pop(s);
						if (w >= 0) begin
							push(s, wword[w]);
							parked[w] = 0; o.kv = 1; o.kt = 4'(w);
						end
					end else if (w >= 0) begin
						o.wv = 1; o.wa = c.dest; o.ww = wword[w];
						parked[w] = 0; o.kv = 1; o.kt = 4'(w);
						o.pre = wprio[w] > c.prio;
					end else begin
						o.status = ST_PARKED;
						park(c.thr, s, 0, c.prio, 0, c.dest);
					end
				end
				default: parked[c.thr] = 0;
			endcase
			if (o.kv) wakes++;
			pending.push_back(o);
		endfunction

		function void check_result(outcome_t a);
			outcome_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result: status %0d", a.status);
				return;
			end
			e = pending.pop_front();
			if (a !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch #%0d exp st%0d wv%0d wa%h ww%h kv%0d kt%0d pre%0d / got st%0d wv%0d wa%h ww%h kv%0d kt%0d pre%0d",
						checked, e.status, e.wv, e.wa, e.ww, e.kv, e.kt, e.pre,
						a.status, a.wv, a.wa, a.ww, a.kv, a.kt, a.pre);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] op;
	logic [31:0] object_key, message, dest_address;
	logic signed [31:0] requested_capacity;
	logic may_wait;
	logic [3:0] caller_thread;
	logic [7:0] caller_priority;
	logic [1:0] status;
	logic write_valid, wake_valid, preempt;
	logic [31:0] write_address, write_word;
	logic [3:0] wake_thread;

	mq_scoreboard sb = new();
	bit [31:0] keys[NQ+1];
	int cycles = 0;
	int calls = 0;

	message_queue_priority_handoff_unit dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL message_queue_priority_handoff_unit");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result('{status, write_valid, write_address, write_word,
				wake_valid, wake_thread, preempt});

	// receiver: changing stall patterns plus one long hold-off
	initial begin
		int n;
		out_ready = 0;
		n = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n++;
			if (n == 4000) begin
				out_ready <= 0;
				repeat (600) @(negedge clk);
			end
			case ((n / 300) % 4)
				0: out_ready <= 1;
				1: out_ready <= ($urandom_range(1, 0) == 1);
				2: out_ready <= (n % 7) < 4;
				default: out_ready <= ($urandom_range(9, 0) != 0);
			endcase
		end
	end

	task automatic issue(call_t c);
		@(negedge clk);
		in_valid <= 1;
		op <= c.op; object_key <= c.key; message <= c.msg; requested_capacity <= c.cap;
		dest_address <= c.dest; may_wait <= c.mw; caller_thread <= c.thr;
		caller_priority <= c.prio;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		sb.note_call(c);
		calls++;
	endtask

	task automatic pause(int n);
		@(negedge clk);
		in_valid <= 0;
		repeat (n - 1) @(negedge clk);
	endtask

	function automatic call_t mk(op_t o, bit [31:0] k, bit [31:0] m, int cap,
		bit [31:0] d, bit w, bit [3:0] t, bit [7:0] p);
		call_t c;
		c.op = o; c.key = k; c.msg = m; c.cap = cap; c.dest = d; c.mw = w; c.thr = t;
		c.prio = p;
		return c;
	endfunction

	function automatic call_t rand_call();
		call_t c;
		int r;
		r = $urandom_range(99, 0);
		c.op = (r < 8) ? OP_CREATE : (r < 50) ? OP_SEND : (r < 92) ? OP_RECEIVE : OP_CANCEL;
		c.key = ($urandom_range(9, 0) == 0) ? $urandom : keys[$urandom_range(NQ - 1, 0)];
		c.msg = $urandom;
		case ($urandom_range(5, 0))
			0: c.cap = $urandom;
			1: c.cap = ND + $urandom_range(3, 0);
			2: c.cap = -$urandom_range(3, 0);
			default: c.cap = $urandom_range(4, 1);
		endcase
		c.dest = $urandom;
		c.mw = $urandom_range(3, 0) != 0;
		c.thr = 4'($urandom);
		c.prio = ($urandom_range(1, 0) == 1) ? 8'($urandom) : 8'($urandom_range(2, 0));
		// only re-create a queue that is empty so its ring never reads stale slots
		if (c.op == OP_CREATE && sb.fill_of(c.key) > 0) c.op = OP_SEND;
		return c;
	endfunction

	initial begin
		int left;
		arst_n = 0; in_valid = 0; op = 0; object_key = 0; message = 0;
		requested_capacity = 0; dest_address = 0; may_wait = 0; caller_thread = 0;
		caller_priority = 0;
		keys[0] = 0;
		keys[1] = 32'hFFFF_FFFF;
		for (int i = 2; i <= NQ; i++) keys[i] = $urandom;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: unknown keys, capacity extremes, table full, hand-offs, ties
		issue(mk(OP_RECEIVE, keys[0], 0, 0, 0, 0, 0, 0));
		issue(mk(OP_SEND, keys[1], 32'hFFFF_FFFF, 0, 0, 1, 15, 255));
		issue(mk(OP_CREATE, keys[0], 0, 1, 0, 0, 0, 0));
		issue(mk(OP_CREATE, keys[1], 0, ND, 0, 0, 0, 0));
		issue(mk(OP_CREATE, keys[2], 0, 0, 0, 0, 0, 0));
		issue(mk(OP_CREATE, keys[3], 0, -1, 0, 0, 0, 0));
		issue(mk(OP_CREATE, keys[4], 0, ND + 1, 0, 0, 0, 0));
		issue(mk(OP_CREATE, keys[5], 0, 32'h8000_0000, 0, 0, 0, 0));
		issue(mk(OP_CREATE, keys[6], 0, 2, 0, 0, 0, 0));
		issue(mk(OP_CREATE, keys[7], 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
		issue(mk(OP_CREATE, keys[8], 0, 3, 0, 0, 0, 0));
		issue(mk(OP_SEND, keys[0], 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		issue(mk(OP_SEND, keys[0], 32'h1234_5678, 0, 0, 0, 1, 9));
		issue(mk(OP_SEND, keys[0], 32'hA5A5_0001, 0, 0, 1, 3, 10));
		issue(mk(OP_RECEIVE, keys[0], 0, 0, 32'hFFFF_FFFF, 0, 5, 200));
		issue(mk(OP_RECEIVE, keys[0], 0, 0, 32'h0000_1000, 0, 5, 200));
		issue(mk(OP_RECEIVE, keys[0], 0, 0, 32'h0000_2000, 0, 6, 0));
		issue(mk(OP_RECEIVE, keys[0], 0, 0, 32'h0000_3000, 0, 7, 0));
		issue(mk(OP_SEND, keys[0], 32'hCAFE_0000, 0, 0, 0, 1, 0));
		issue(mk(OP_CANCEL, keys[0], 0, 0, 0, 0, 7, 0));
		issue(mk(OP_CANCEL, keys[0], 0, 0, 0, 0, 9, 0));
		issue(mk(OP_RECEIVE, keys[2], 0, 0, 32'h0000_4000, 0, 10, 200));
		issue(mk(OP_RECEIVE, keys[2], 0, 0, 32'h0000_5000, 0, 10, 255));
		issue(mk(OP_SEND, keys[2], 32'h0BAD_F00D, 0, 0, 0, 11, 10));
		issue(mk(OP_CREATE, keys[0], 0, ND, 0, 0, 0, 0));

		left = RANDOM_ITEMS;
		while (left > 0) begin
			int burst;
			burst = $urandom_range(20, 1);
			for (int i = 0; i < burst && left > 0; i++, left--) issue(rand_call());
			if ($urandom_range(3, 0) != 0) pause($urandom_range(6, 1));
		end
		@(negedge clk);
		in_valid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d calls, %0d results checked, %0d wakes, %0d parks",
			calls, sb.checked, sb.wakes, sb.parks);
		if (sb.errors == 0) begin
			$display("PASS message_queue_priority_handoff_unit");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("FAIL message_queue_priority_handoff_unit");
		end
		$finish;
	end
endmodule

>>> sim.f
hdl/mqph_pkg.sv
hdl/mqph_ram.sv
hdl/message_queue_priority_handoff_unit.sv
bench/message_queue_priority_handoff_unit_tb.sv
